/* design/spq_pkg.sv */
// Shared types and codes for the stable priority queue.
// Used by spq_ctrl, spq_dpath and stable_priority_queue; depends on nothing.
package spq_pkg;

    // Default number of stored entries.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Opcodes of the request word.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SERVE  = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    // Status codes of the response word.
    localparam logic [1:0] ST_GIVEN  = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ACCEPT = 2'd3;

    // Request word.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  priority_req;
        logic [7:0]  age;
        logic [15:0] tag;
    } req_t;

    // Response word.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_priority;
        logic [7:0]  out_age;
        logic [15:0] out_tag;
        logic        last;
    } rsp_t;

    // One stored entry.
    typedef struct packed {
        logic [7:0]  prio;
        logic [7:0]  age;
        logic [15:0] tag;
    } entry_t;

    // Which kind of response the datapath loads into its output register.
    typedef enum logic [1:0] {
        RES_ENTRY,
        RES_EMPTY,
        RES_FULL,
        RES_ACCEPT
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     do_insert;
        logic     do_serve;
        logic     load;
        res_sel_t sel;
        logic     last;
        logic     idx_inc;
        logic     idx_clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
    } sts_t;

endpackage

/* design/spq_ctrl.sv */
// Controller of the stable priority queue: request/response handshake and list walk.
// Depends on spq_pkg for the command, status and opcode definitions.
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  logic [1:0]    opcode,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  spq_pkg::sts_t sts,
    output spq_pkg::cmd_t cmd
);

    typedef enum logic {
        S_RUN,
        S_LIST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    // The output register can take a new word when it is empty or being drained.
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // Decode of the request and sequencing of a list walk.
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.sel    = spq_pkg::RES_ENTRY;
        case (state_reg)
            S_RUN:
            begin
                req_ready = slot_free;
                if (req_valid && slot_free)
                begin
                    case (opcode)
                        spq_pkg::OP_INSERT:
                        begin
                            cmd.load = 1'b1;
                            cmd.last = 1'b1;
                            if (sts.full)
                            begin
                                cmd.sel = spq_pkg::RES_FULL;
                            end
                            else
                            begin
                                cmd.sel       = spq_pkg::RES_ACCEPT;
                                cmd.do_insert = 1'b1;
                            end
                        end
                        spq_pkg::OP_SERVE:
                        begin
                            cmd.load = 1'b1;
                            cmd.last = 1'b1;
                            if (sts.empty)
                            begin
                                cmd.sel = spq_pkg::RES_EMPTY;
                            end
                            else
                            begin
                                cmd.sel      = spq_pkg::RES_ENTRY;
                                cmd.do_serve = 1'b1;
                            end
                        end
                        spq_pkg::OP_LIST:
                        begin
                            cmd.load = 1'b1;
                            if (sts.empty)
                            begin
                                cmd.sel  = spq_pkg::RES_EMPTY;
                                cmd.last = 1'b1;
                            end
                            else
                            begin
                                // The list index rests at zero, so the head goes first.
                                cmd.sel  = spq_pkg::RES_ENTRY;
                                cmd.last = sts.list_last;
                                if (sts.list_last)
                                begin
                                    cmd.idx_clear = 1'b1;
                                end
                                else
                                begin
                                    cmd.idx_inc = 1'b1;
                                    state_next  = S_LIST;
                                end
                            end
                        end
                        default:
                        begin
                            // The unused opcode is taken and dropped.
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (slot_free)
                begin
                    cmd.load = 1'b1;
                    cmd.sel  = spq_pkg::RES_ENTRY;
                    cmd.last = sts.list_last;
                    if (sts.list_last)
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = S_RUN;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // A loaded word is valid until the consumer takes it.
    always_comb
    begin
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

/* design/spq_dpath.sv */
// Datapath of the stable priority queue: sorted shifting row of entries, count,
// list index and response register. Depends on spq_pkg for word and command types.
module spq_dpath #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::cmd_t cmd,
    input  spq_pkg::req_t req,
    output spq_pkg::rsp_t rsp,
    output spq_pkg::sts_t sts
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    spq_pkg::entry_t           entry_reg  [QUEUE_DEPTH];
    spq_pkg::entry_t           entry_next [QUEUE_DEPTH];
    spq_pkg::entry_t           prev_entry [QUEUE_DEPTH];
    spq_pkg::entry_t           succ_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    stay;
    logic [QUEUE_DEPTH-1:0]    prev_stay;
    spq_pkg::entry_t           new_entry;
    spq_pkg::entry_t           sel_entry;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    spq_pkg::rsp_t             rsp_reg;
    spq_pkg::rsp_t             rsp_next;

    assign new_entry.prio = req.priority_req;
    assign new_entry.age  = req.age;
    assign new_entry.tag  = req.tag;

    // Each cell keeps its entry, takes the new one, or moves by one place.
    // Cells at or below a lower-or-equal priority stay, which keeps ties in arrival order.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign stay[i] = (CNT_W'(i) < count_reg) && (entry_reg[i].prio <= new_entry.prio);

        if (i == 0)
        begin : g_head
            assign prev_stay[i]  = 1'b1;
            assign prev_entry[i] = new_entry;
        end
        else
        begin : g_body
            assign prev_stay[i]  = stay[i-1];
            assign prev_entry[i] = entry_reg[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign succ_entry[i] = entry_reg[i];
        end
        else
        begin : g_inner
            assign succ_entry[i] = entry_reg[i+1];
        end

        always_comb
        begin
            entry_next[i] = entry_reg[i];
            if (cmd.do_insert)
            begin
                if (stay[i])
                begin
                    entry_next[i] = entry_reg[i];
                end
                else if (prev_stay[i])
                begin
                    entry_next[i] = new_entry;
                end
                else
                begin
                    entry_next[i] = prev_entry[i];
                end
            end
            else if (cmd.do_serve)
            begin
                entry_next[i] = succ_entry[i];
            end
        end

        always_ff @(posedge clk)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    // Entry count.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.do_serve)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // List index; it rests at zero between walks, so serve reads the head too.
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Status for the controller.
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign sts.list_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Response word selection.
    assign sel_entry = entry_reg[idx_reg];

    always_comb
    begin
        rsp_next      = '0;
        rsp_next.last = cmd.last;
        case (cmd.sel)
            spq_pkg::RES_ENTRY:
            begin
                rsp_next.status       = spq_pkg::ST_GIVEN;
                rsp_next.out_priority = sel_entry.prio;
                rsp_next.out_age      = sel_entry.age;
                rsp_next.out_tag      = sel_entry.tag;
            end
            spq_pkg::RES_EMPTY:
            begin
                rsp_next.status = spq_pkg::ST_EMPTY;
            end
            spq_pkg::RES_FULL:
            begin
                rsp_next.status = spq_pkg::ST_FULL;
            end
            spq_pkg::RES_ACCEPT:
            begin
                rsp_next.status = spq_pkg::ST_ACCEPT;
            end
            default:
            begin
                rsp_next.status = spq_pkg::ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

/* design/stable_priority_queue.sv */
// Top level of the stable priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
//
//  Channel   Handshake              Word          Direction
//  request   req_valid / req_ready  req  (req_t)  into the block
//  response  rsp_valid / rsp_ready  rsp  (rsp_t)  out of the block
//
// Insert and serve each give one response word: the sorted register row shifts all its cells together.
// List gives one response word per stored entry through the single read
// mux on the row; an empty list or serve gives one word.
// Reset clears the entry count and the list index; stored entries are left undefined.
// req_ready drops while an untaken response word sits in the output register and during a
// list walk; a stalled response holds its word.
module stable_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spq_pkg::rsp_t rsp
);

    spq_pkg::cmd_t cmd;
    spq_pkg::sts_t sts;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .opcode    (req.opcode),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    spq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp),
        .sts   (sts)
    );

    // The queue only changes on an accepted request word.
    a_change_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_insert || cmd.do_serve) |-> (req_valid && req_ready))
        else $error("queue changed without an accepted request");

    // No insert into a full queue and no removal from an empty one.
    a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |-> !sts.full)
        else $error("insert into a full queue");

    a_serve_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_serve |-> !sts.empty)
        else $error("serve from an empty queue");

    // A word that carries no entry is always marked last; only a list walk gives words that are not.
    a_last_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != spq_pkg::ST_GIVEN)) |-> rsp.last)
        else $error("non-entry response not marked last");

endmodule
